[src/izhikevich_neuron_step_core_defines.svh]
// Assertion macros used by the neuron step core.
`ifndef IZHIKEVICH_NEURON_STEP_CORE_DEFINES_SVH
`define IZHIKEVICH_NEURON_STEP_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define IZNS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IZNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define IZNS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define IZNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/izns_pkg.sv]
// Shared widths and types of the neuron step core.
`default_nettype none

package izns_pkg;

   // Field widths of the channel words.
   localparam int unsigned INDEX_W   = 8;
   localparam int unsigned CURRENT_W = 25;
   localparam int unsigned VOLT_W    = 25;

   // Iterative divider: dividend width and quotient bits retired per cycle.
   localparam int unsigned DIV_W      = 48;
   localparam int unsigned DIV_STEP   = 8;
   localparam int unsigned DIV_ITERS  = DIV_W / DIV_STEP;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITERS);
   localparam int unsigned DIVISOR_W  = 5;
   localparam int unsigned REMAINDER_W = 4;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [16:0] rate;
      logic [16:0] coupling;
      logic [24:0] reset_voltage;
      logic [21:0] jump;
      logic [24:0] threshold;
      logic [4:0]  substeps;
   } izns_cfg_type;

   // Divider request and response.
   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } izns_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } izns_div_rsp_type;

endpackage

`default_nettype wire

[src/izns_if.sv]
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface izns_req_if;
   logic                                      valid;
   logic                                      ready;
   logic        [izns_pkg::INDEX_W-1:0]       neuron_index;
   logic signed [izns_pkg::CURRENT_W-1:0]     direct_current;
   logic signed [izns_pkg::CURRENT_W-1:0]     synaptic_current;

   modport source (output valid, neuron_index, direct_current, synaptic_current,
                   input ready);
   modport sink (input valid, neuron_index, direct_current, synaptic_current,
                 output ready);
endinterface

interface izns_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [izns_pkg::INDEX_W-1:0]   neuron_number;
   logic signed [izns_pkg::VOLT_W-1:0]    membrane_voltage;
   logic                                  spiked;

   modport source (output valid, neuron_number, membrane_voltage, spiked,
                   input ready);
   modport sink (input valid, neuron_number, membrane_voltage, spiked,
                 output ready);
endinterface

`default_nettype wire

[src/izns_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module izns_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire                                   clock,
   input  wire                                   wr_en,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                      wr_data,
   input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/izns_csr.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module izns_csr (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [4:0]                   paddr,
   input  wire  [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output izns_pkg::izns_cfg_type       cfg
);

   typedef enum logic [2:0] {
      REG_RATE,
      REG_COUPLING,
      REG_RESET_V,
      REG_JUMP,
      REG_THRESHOLD,
      REG_SUBSTEPS
   } reg_index_type;

   // Reset values: a = 0.02, b = 0.2, c = -65, d = 8, threshold = 30, two substeps.
   localparam logic [16:0] RATE_DEF      = 17'h0051F;
   localparam logic [16:0] COUPLING_DEF  = 17'h03333;
   localparam logic [24:0] RESET_V_DEF   = 25'h1BF0000;
   localparam logic [21:0] JUMP_DEF      = 22'h080000;
   localparam logic [24:0] THRESHOLD_DEF = 25'h01E0000;
   localparam logic [4:0]  SUBSTEPS_DEF  = 5'd2;

   izns_pkg::izns_cfg_type cfg_ff, cfg_in;
   logic                   wr_en;
   logic [2:0]             reg_index;

   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[4:2];

   // Register write decode; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_RATE:      cfg_in.rate          = pwdata[16:0];
            REG_COUPLING:  cfg_in.coupling      = pwdata[16:0];
            REG_RESET_V:   cfg_in.reset_voltage = pwdata[24:0];
            REG_JUMP:      cfg_in.jump          = pwdata[21:0];
            REG_THRESHOLD: cfg_in.threshold     = pwdata[24:0];
            REG_SUBSTEPS:  cfg_in.substeps      = pwdata[4:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate          <= RATE_DEF;
         cfg_ff.coupling      <= COUPLING_DEF;
         cfg_ff.reset_voltage <= RESET_V_DEF;
         cfg_ff.jump          <= JUMP_DEF;
         cfg_ff.threshold     <= THRESHOLD_DEF;
         cfg_ff.substeps      <= SUBSTEPS_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_index)
         REG_RATE:      prdata = {15'd0, cfg_ff.rate};
         REG_COUPLING:  prdata = {15'd0, cfg_ff.coupling};
         REG_RESET_V:   prdata = {7'd0, cfg_ff.reset_voltage};
         REG_JUMP:      prdata = {10'd0, cfg_ff.jump};
         REG_THRESHOLD: prdata = {7'd0, cfg_ff.threshold};
         REG_SUBSTEPS:  prdata = {27'd0, cfg_ff.substeps};
         default:       prdata = 32'd0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

[src/izns_div.sv]
// Iterative unsigned divider by a small divisor, eight quotient bits per cycle.
`default_nettype none

module izns_div (
   input  wire                          clock,
   input  wire                          reset,
   input  izns_pkg::izns_div_req_type   div_req,
   output izns_pkg::izns_div_rsp_type   div_rsp
);

   localparam int unsigned W  = izns_pkg::DIV_W;
   localparam int unsigned CW = izns_pkg::DIV_CNT_W;
   localparam int unsigned RW = izns_pkg::REMAINDER_W;
   localparam int unsigned DW = izns_pkg::DIVISOR_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;

   // Restoring division: the remainder stays below the divisor, so it is narrow.
   always_comb begin
      logic [W-1:0]  num_t;
      logic [W-1:0]  quo_t;
      logic [RW-1:0] rem_t;
      logic [DW-1:0] part;

      num_t   = num_ff;
      quo_t   = quo_ff;
      rem_t   = rem_ff;
      part    = '0;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;

      for (int k = 0; k < izns_pkg::DIV_STEP; k++) begin
         part  = {rem_t, num_t[W-1]};
         num_t = {num_t[W-2:0], 1'b0};
         if (part >= den_ff) begin
            rem_t = RW'(part - den_ff);
            quo_t = {quo_t[W-2:0], 1'b1};
         end else begin
            rem_t = part[RW-1:0];
            quo_t = {quo_t[W-2:0], 1'b0};
         end
      end

      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;

      if (div_req.start && !busy_ff) begin
         num_in  = div_req.dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_t;
         quo_in = quo_t;
         rem_in = rem_t;
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(izns_pkg::DIV_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

[src/izhikevich_neuron_step_core.sv]
// Izhikevich neuron population updater: one neuron advanced one tick per request word.
//
// Usage: a request word on req_chan names a neuron and carries its direct and
// synaptic currents. Exactly one response word follows on rsp_chan with the
// neuron number, its new voltage clamped to the threshold and saturated to 25
// bits, and a flag that tells whether the neuron fired at the start of the tick.
// Voltage and recovery of every neuron live in two RAMs with registered reads;
// each word is read, updated and written back before the next word is taken.
// The effective substep count is 1 to 16, two by default. Each Euler substep
// costs a square, a scale, a sum and a pass through the iterative divider that
// forms dv/n. Reset: the registers return to their defaults, then a clearing
// pass writes the resting voltage and recovery into every RAM entry; no request
// is taken during it. Configuration writes are taken at all times. A stalled
// receiver holds the response in its output register; the next request is
// still taken and processed, and its writeback waits until the output register
// is free.
`default_nettype none
`include "izhikevich_neuron_step_core_defines.svh"

module izhikevich_neuron_step_core #(
   parameter int unsigned NEURONS = 256
) (
   input  wire                clock,
   input  wire                reset,
   izns_req_if.sink           req_chan,
   izns_rsp_if.source         rsp_chan,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [4:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int unsigned IDX_W      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int unsigned INDEX_SPAN = 1 << izns_pkg::INDEX_W;

   // Model constants in Q16.16.
   localparam logic [11:0]        K_QUAD     = 12'd2621;
   localparam logic signed [31:0] K_OFFSET   = 32'sd9175040;
   localparam logic [31:0]        V_INIT     = 32'hFFBF0000;
   localparam logic [31:0]        U_INIT     = 32'hFFF30000;
   localparam logic signed [47:0] SAT32_MAX  = 48'sd2147483647;
   localparam logic signed [47:0] SAT32_MIN  = -48'sd2147483648;
   localparam logic signed [31:0] SAT25_MAX  = 32'sd16777215;
   localparam logic signed [31:0] SAT25_MIN  = -32'sd16777216;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_QUAD,
      ST_DERIV,
      ST_DIV,
      ST_COUPLE,
      ST_DIFF,
      ST_RECOV,
      ST_WRITE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      logic signed [31:0] r;
      if (x > SAT32_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [24:0] sat25(input logic signed [31:0] x);
      logic [24:0] r;
      if (x > SAT25_MAX) begin
         r = 25'h0FFFFFF;
      end else if (x < SAT25_MIN) begin
         r = 25'h1000000;
      end else begin
         r = x[24:0];
      end
      return r;
   endfunction

   izns_pkg::izns_cfg_type     cfg;
   izns_pkg::izns_div_req_type div_req;
   izns_pkg::izns_div_rsp_type div_rsp;

   // Control registers.
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [3:0]         step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath and payload registers.
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [25:0] cur_ff, cur_in;
   logic signed [31:0] v_ff, v_in;
   logic signed [31:0] u_ff, u_in;
   logic signed [31:0] uold_ff, uold_in;
   logic               fired_ff, fired_in;
   logic [46:0]        sq_ff, sq_in;
   logic [42:0]        quad_ff, quad_in;
   logic               dv_neg_ff, dv_neg_in;
   logic signed [32:0] bv_ff, bv_in;
   logic signed [33:0] diff_ff, diff_in;
   logic signed [35:0] du_ff, du_in;
   logic [7:0]         rsp_idx_ff, rsp_idx_in;
   logic [24:0]        rsp_volt_ff, rsp_volt_in;
   logic               rsp_spk_ff, rsp_spk_in;

   // RAM ports.
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [31:0]        vmem_wdata, umem_wdata;
   logic [IDX_W-1:0]   mem_raddr;
   logic [31:0]        vmem_rdata, umem_rdata;

   logic [IDX_W-1:0]   idx_lut [INDEX_SPAN];
   logic [4:0]         n_eff;
   logic               req_fire;
   logic               rsp_free;
   logic signed [31:0] thr32;

   izns_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   izns_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   izns_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_vmem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (vmem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (vmem_rdata)
   );

   izns_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_umem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (umem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (umem_rdata)
   );

   // Request index folded into the population size.
   for (genvar g = 0; g < INDEX_SPAN; g++) begin : g_idx_lut
      localparam int unsigned FOLDED = g % NEURONS;
      assign idx_lut[g] = IDX_W'(FOLDED);
   end

   // Substep count saturated into 1..16.
   always_comb begin
      if (cfg.substeps == 5'd0) begin
         n_eff = 5'd1;
      end else if (cfg.substeps > 5'd16) begin
         n_eff = 5'd16;
      end else begin
         n_eff = cfg.substeps;
      end
   end

   assign thr32    = 32'($signed(cfg.threshold));
   assign req_fire = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign mem_raddr = idx_lut[req_chan.neuron_index];

   // Sequencer and datapath next-state logic.
   always_comb begin
      logic [31:0]        mag;
      logic [63:0]        sq_prod;
      logic [58:0]        quad_prod;
      logic signed [45:0] dv;
      logic [44:0]        dv_mag;
      logic signed [45:0] q_signed;
      logic signed [45:0] v_sum;
      logic signed [49:0] bv_prod;
      logic signed [51:0] du_prod;
      logic signed [31:0] v_fin;
      logic signed [31:0] u_new;

      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      uold_in      = uold_ff;
      fired_in     = fired_ff;
      sq_in        = sq_ff;
      quad_in      = quad_ff;
      dv_neg_in    = dv_neg_ff;
      bv_in        = bv_ff;
      diff_in      = diff_ff;
      du_in        = du_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_volt_in  = rsp_volt_ff;
      rsp_spk_in   = rsp_spk_ff;

      mem_we     = 1'b0;
      mem_waddr  = idx_ff;
      vmem_wdata = V_INIT;
      umem_wdata = U_INIT;

      div_req.start    = 1'b0;
      div_req.divisor  = n_eff;

      // Shared arithmetic of the states below.
      mag       = v_ff[31] ? (~v_ff + 32'd1) : v_ff;
      sq_prod   = 64'(mag) * 64'(mag);
      quad_prod = 59'(sq_ff) * 59'(K_QUAD);
      dv        = $signed({3'b000, quad_ff}) + 46'(v_ff) + (46'(v_ff) <<< 2)
                  + 46'(K_OFFSET) - 46'(uold_ff) + 46'(cur_ff);
      dv_mag    = dv[45] ? 45'(-dv) : 45'(dv);
      div_req.dividend = izns_pkg::DIV_W'(dv_mag);
      q_signed  = dv_neg_ff ? -$signed({2'b00, div_rsp.quotient[43:0]})
                            : $signed({2'b00, div_rsp.quotient[43:0]});
      v_sum     = 46'(v_ff) + q_signed;
      bv_prod   = $signed({1'b0, cfg.coupling}) * v_ff;
      du_prod   = $signed({1'b0, cfg.rate}) * diff_ff;
      v_fin     = (v_ff >= thr32) ? thr32 : v_ff;
      u_new     = sat32(48'(u_ff) + 48'(du_ff));

      // The response register drains independently of the work in progress.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Write resting values into every entry after reset.
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            if (clr_addr_ff == IDX_W'(NEURONS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = IDX_W'(clr_addr_ff + 1'b1);
            end
         end
         // Take a word; its entry is read at this edge.
         ST_IDLE: begin
            if (req_fire) begin
               idx_in   = mem_raddr;
               cur_in   = 26'(req_chan.direct_current) + 26'(req_chan.synaptic_current);
               state_in = ST_LOAD;
            end
         end
         // Spike check against the stored voltage.
         ST_LOAD: begin
            uold_in  = $signed(umem_rdata);
            fired_in = $signed(vmem_rdata) >= thr32;
            step_in  = '0;
            if ($signed(vmem_rdata) >= thr32) begin
               v_in = 32'($signed(cfg.reset_voltage));
               u_in = sat32(48'($signed(umem_rdata)) + $signed({26'd0, cfg.jump}));
            end else begin
               v_in = $signed(vmem_rdata);
               u_in = $signed(umem_rdata);
            end
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            sq_in    = 47'((sq_prod + 64'd32768) >> 16);
            state_in = ST_QUAD;
         end
         ST_QUAD: begin
            quad_in  = 43'((quad_prod + 59'd32768) >> 16);
            state_in = ST_DERIV;
         end
         // Form dv and hand its magnitude to the divider.
         ST_DERIV: begin
            dv_neg_in     = dv[45];
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         // Apply dv/n with truncation toward zero, then saturate.
         ST_DIV: begin
            if (div_rsp.done) begin
               v_in = sat32(48'(v_sum));
               if (step_ff == 4'(n_eff - 5'd1)) begin
                  state_in = ST_COUPLE;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_COUPLE: begin
            bv_in    = 33'((bv_prod + 50'sd32768) >>> 16);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = 34'(bv_ff) - 34'(u_ff);
            state_in = ST_RECOV;
         end
         ST_RECOV: begin
            du_in    = 36'((du_prod + 52'sd32768) >>> 16);
            state_in = ST_WRITE;
         end
         // Write back and load the response once the output register is free.
         ST_WRITE: begin
            if (rsp_free) begin
               mem_we       = 1'b1;
               mem_waddr    = idx_ff;
               vmem_wdata   = v_fin;
               umem_wdata   = u_new;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 8'(idx_ff);
               rsp_volt_in  = sat25(v_fin);
               rsp_spk_in   = fired_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      v_ff        <= v_in;
      u_ff        <= u_in;
      uold_ff     <= uold_in;
      fired_ff    <= fired_in;
      sq_ff       <= sq_in;
      quad_ff     <= quad_in;
      dv_neg_ff   <= dv_neg_in;
      bv_ff       <= bv_in;
      diff_ff     <= diff_in;
      du_ff       <= du_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_volt_ff <= rsp_volt_in;
      rsp_spk_ff  <= rsp_spk_in;
   end

   // Channel outputs.
   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.neuron_number    = rsp_idx_ff;
   assign rsp_chan.membrane_voltage = rsp_volt_ff;
   assign rsp_chan.spiked           = rsp_spk_ff;

   // The RAMs are written only by the clearing pass or at writeback.
   `IZNS_ASSERT_IMPLY(a_mem_write_state, clock, reset, mem_we,
      (state_ff == ST_CLEAR) || (state_ff == ST_WRITE), "RAM written outside clear or writeback")

   // A divider result only arrives while the sequencer waits for it.
   `IZNS_ASSERT_IMPLY(a_div_done_state, clock, reset, div_rsp.done,
      state_ff == ST_DIV, "divider finished outside the divide state")

   // Writeback with a free output register presents the response next cycle.
   `IZNS_ASSERT_NEXT(a_writeback_rsp, clock, reset, (state_ff == ST_WRITE) && rsp_free,
      rsp_chan.valid && (state_ff == ST_IDLE), "writeback did not load the response")

endmodule

`default_nettype wire

[tb/sv/izhikevich_neuron_step_core_tb.sv]
// Self-checking testbench for the Izhikevich neuron step core.
`timescale 1ns / 100ps

module izhikevich_neuron_step_core_tb;

   localparam int unsigned NEURONS      = 256;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned SETTLE_DELAY = 200;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned HOLD_CYCLES  = 900;

   // Field widths of the channel words.
   localparam int unsigned INDEX_W   = izns_pkg::INDEX_W;
   localparam int unsigned CURRENT_W = izns_pkg::CURRENT_W;
   localparam int unsigned VOLT_W    = izns_pkg::VOLT_W;

   // Q16.16 constants of the neuron equation.
   localparam longint HALF_LSB    = 32768;
   localparam longint QUAD_GAIN   = 2621;
   localparam longint DRIFT_TERM  = 9175040;
   localparam longint REST_V      = -4259840;
   localparam longint REST_U      = -851968;
   localparam longint WORD32_MAX  = 64'sd2147483647;
   localparam longint WORD32_MIN  = -64'sd2147483648;
   localparam longint REPORT_MAX  = 16777215;
   localparam longint REPORT_MIN  = -16777216;

   // Register map, one 32-bit register every four bytes.
   typedef enum logic [2:0] {
      REG_RECOVERY_RATE,
      REG_RECOVERY_COUPLING,
      REG_RESET_VOLTAGE,
      REG_RECOVERY_JUMP,
      REG_SPIKE_THRESHOLD,
      REG_SUBSTEP_COUNT,
      REG_SPARE_A,
      REG_SPARE_B
   } csr_index_type;

   typedef struct packed {
      logic        [INDEX_W-1:0]   index;
      logic signed [CURRENT_W-1:0] direct;
      logic signed [CURRENT_W-1:0] synaptic;
   } stim_word_type;

   typedef struct packed {
      logic        [INDEX_W-1:0] number;
      logic signed [VOLT_W-1:0]  voltage;
      logic                      spiked;
   } neuron_result_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   izns_req_if req_chan ();
   izns_rsp_if rsp_chan ();

   izhikevich_neuron_step_core #(
      .NEURONS (NEURONS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Predictor state: neuron stores and the register copy.
   logic signed [31:0] voltage_mem  [NEURONS];
   logic signed [31:0] recovery_mem [NEURONS];
   longint rate_q;
   longint coupling_q;
   longint reset_v_q;
   longint jump_q;
   longint threshold_q;
   longint substep_q;

   stim_word_type     pending_words [$];
   neuron_result_type expected_updates [$];
   int unsigned       words_queued;
   int unsigned       words_accepted;
   int unsigned       failure_count;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       cycle_count;
   int unsigned       hold_left;
   bit                hold_requested;
   bit                hold_done;

   function automatic longint clip32(input longint x);
      if (x > WORD32_MAX) return WORD32_MAX;
      if (x < WORD32_MIN) return WORD32_MIN;
      return x;
   endfunction

   // Advance one neuron by one tick and return the word the core should report.
   function automatic neuron_result_type advance_neuron(input logic [INDEX_W-1:0] index,
         input logic signed [CURRENT_W-1:0] direct,
         input logic signed [CURRENT_W-1:0] synaptic);
      neuron_result_type r;
      longint current;
      longint v;
      longint u;
      longint u_before;
      longint mag;
      longint sq;
      longint quad;
      longint dv;
      longint bv;
      longint du;
      longint steps;
      bit     fired;
      current  = longint'(direct) + longint'(synaptic);
      v        = longint'(voltage_mem[index]);
      u_before = longint'(recovery_mem[index]);
      u        = u_before;
      fired    = (v >= threshold_q);
      steps    = substep_q;
      if (steps < 1) steps = 1;
      if (steps > 16) steps = 16;

      // A spike restarts the voltage and bumps the recovery.
      if (fired) begin
         v = reset_v_q;
         u = clip32(u_before + jump_q);
      end

      // Euler substeps always use the recovery from before the spike.
      for (int s = 0; s < steps; s++) begin
         mag  = (v < 0) ? -v : v;
         sq   = (mag * mag + HALF_LSB) >> 16;
         quad = (sq * QUAD_GAIN + HALF_LSB) >> 16;
         dv   = quad + 5 * v + DRIFT_TERM - u_before + current;
         v    = clip32(v + dv / steps);
      end

      // Recovery update with round-half-up products.
      bv = (coupling_q * v + HALF_LSB) >>> 16;
      du = (rate_q * (bv - u) + HALF_LSB) >>> 16;
      u  = clip32(u + du);

      if (v >= threshold_q) v = threshold_q;
      voltage_mem[index]  = 32'(v);
      recovery_mem[index] = 32'(u);

      if (v > REPORT_MAX) v = REPORT_MAX;
      if (v < REPORT_MIN) v = REPORT_MIN;
      r.number  = index;
      r.voltage = VOLT_W'(v);
      r.spiked  = fired;
      return r;
   endfunction

   // Mostly moderate drive, some full-range and some raw 25-bit patterns.
   function automatic logic signed [CURRENT_W-1:0] draw_current();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) return CURRENT_W'(int'($urandom_range(0, 30 << 16)) - (5 << 16));
      if (pick < 85) return CURRENT_W'(int'($urandom_range(0, 16777216)) - 8388608);
      return CURRENT_W'($urandom);
   endfunction

   task automatic queue_word(input int index, input int direct, input int synaptic);
      stim_word_type w;
      w.index    = INDEX_W'(index);
      w.direct   = CURRENT_W'(direct);
      w.synaptic = CURRENT_W'(synaptic);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Random words concentrate on a few neurons so that they build up and fire.
   task automatic queue_random_words(input int unsigned count);
      stim_word_type w;
      @(negedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         w.index    = ($urandom_range(99) < 70) ? INDEX_W'($urandom_range(0, 7))
                                                : INDEX_W'($urandom_range(0, 255));
         w.direct   = draw_current();
         w.synaptic = draw_current();
         pending_words.push_back(w);
         words_queued++;
      end
   endtask

   // Sender pause: wait until every word is taken and answered.
   task automatic settle_block();
      while (words_accepted != words_queued || expected_updates.size() != 0)
         @(negedge clock);
   endtask

   // Two-phase register write; the predictor copy follows at the access edge.
   task automatic write_register(input csr_index_type reg_sel, input int value);
      logic [31:0] data;
      data = 32'(value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (reg_sel)
         REG_RECOVERY_RATE:     rate_q      = longint'(data[16:0]);
         REG_RECOVERY_COUPLING: coupling_q  = longint'(data[16:0]);
         REG_RESET_VOLTAGE:     reset_v_q   = longint'($signed(data[24:0]));
         REG_RECOVERY_JUMP:     jump_q      = longint'(data[21:0]);
         REG_SPIKE_THRESHOLD:   threshold_q = longint'($signed(data[24:0]));
         REG_SUBSTEP_COUNT:     substep_q   = longint'(data[4:0]);
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int rate, input int coupling, input int reset_v,
         input int jump, input int threshold, input int substeps);
      write_register(REG_RECOVERY_RATE, rate);
      write_register(REG_RECOVERY_COUPLING, coupling);
      write_register(REG_RESET_VOLTAGE, reset_v);
      write_register(REG_RECOVERY_JUMP, jump);
      write_register(REG_SPIKE_THRESHOLD, threshold);
      write_register(REG_SUBSTEP_COUNT, substeps);
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: presents the oldest pending word and predicts it on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid            <= 1'b0;
         req_chan.neuron_index     <= '0;
         req_chan.direct_current   <= '0;
         req_chan.synaptic_current <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_updates.push_back(advance_neuron(req_chan.neuron_index,
               req_chan.direct_current, req_chan.synaptic_current));
            void'(pending_words.pop_front());
            words_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid            <= 1'b1;
               req_chan.neuron_index     <= pending_words[0].index;
               req_chan.direct_current   <= pending_words[0].direct;
               req_chan.synaptic_current <= pending_words[0].synaptic;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the core backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_requested && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: each word is checked against the oldest prediction.
   always @(posedge clock) begin : response_check
      neuron_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_updates.size() == 0) begin
               if (failure_count < REPORT_LIMIT)
                  $display("%0t: unexpected word: neuron %0d voltage %0d spiked %0d", $time,
                     rsp_chan.neuron_number, rsp_chan.membrane_voltage, rsp_chan.spiked);
               failure_count++;
            end else begin
               want = expected_updates.pop_front();
               if (rsp_chan.neuron_number !== want.number ||
                     rsp_chan.membrane_voltage !== want.voltage ||
                     rsp_chan.spiked !== want.spiked) begin
                  if (failure_count < REPORT_LIMIT)
                     $display("%0t: mismatch: expected neuron %0d voltage %0d spiked %0d, %s",
                        $time, want.number, want.voltage, want.spiked,
                        $sformatf("got neuron %0d voltage %0d spiked %0d",
                           rsp_chan.neuron_number, rsp_chan.membrane_voltage,
                           rsp_chan.spiked));
                  failure_count++;
               end
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on the cycle count.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL izhikevich_neuron_step_core");
      $finish;
   end

   // Stimulus sequence: directed words, then random words under several settings.
   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      hold_requested = 1'b0;
      rate_q         = 1311;
      coupling_q     = 13107;
      reset_v_q      = REST_V;
      jump_q         = 524288;
      threshold_q    = 1966080;
      substep_q      = 2;
      words_queued   = 0;
      words_accepted = 0;
      failure_count  = 0;
      send_idle_pct  = 14;
      recv_idle_pct  = 59;
      for (int i = 0; i < NEURONS; i++) begin
         voltage_mem[i]  = 32'(REST_V);
         recovery_mem[i] = 32'(REST_U);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: field extremes, firing, saturation.
      @(negedge clock);
      queue_word(0, 0, 0);
      queue_word(255, 0, 0);
      queue_word(1, 8388608, 0);
      queue_word(1, 0, 8388608);
      repeat (4) queue_word(2, 8388608, 8388608);
      queue_word(3, -8388608, -8388608);
      queue_word(3, -16777216, -16777216);
      queue_word(3, -16777216, -16777216);
      queue_word(3, 0, 0);
      queue_word(4, 16777215, 16777215);
      queue_word(4, 16777215, 16777215);
      queue_word(4, 0, 0);
      repeat (4) queue_word(5, 655360, 0);
      queue_word(128, 1, -1);
      queue_word(170, 11184810, -5592406);
      queue_word(85, -11184811, 5592405);
      settle_block();

      // Extremes one way: fastest recovery, no coupling, single substep.
      apply_settings(65536, 0, 8388608, 2097152, -8388608, 1);
      queue_random_words(150);
      settle_block();

      // Extremes the other way: sixteen substeps.
      apply_settings(0, 65536, -8388608, 0, 8388608, 16);
      queue_random_words(40);
      settle_block();

      // Fully random parameters with a zero substep count; idling swapped.
      send_idle_pct = 59;
      recv_idle_pct = 14;
      apply_settings($urandom_range(0, 65536), $urandom_range(0, 65536),
         int'($urandom_range(0, 16777216)) - 8388608, $urandom_range(0, 2097152),
         int'($urandom_range(0, 16777216)) - 8388608, 0);
      queue_random_words(150);
      settle_block();

      // Default neuron with an oversized substep count.
      apply_settings(1311, 13107, -4259840, 524288, 1966080, 31);
      queue_random_words(30);
      settle_block();

      // No idling; writes to unmapped registers must change nothing.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(REG_SPARE_A, -1);
      write_register(REG_SPARE_B, 32'h5A5A5A5A);
      write_register(REG_SUBSTEP_COUNT, 2);
      queue_random_words(250);
      while (words_accepted + 210 < words_queued) @(negedge clock);
      hold_requested = 1'b1;
      settle_block();

      // Random but plausible neuron types.
      apply_settings($urandom_range(0, 8000), $urandom_range(0, 30000),
         int'($urandom_range(40, 70)) * -65536, $urandom_range(0, 600000),
         int'($urandom_range(20, 40)) * 65536, $urandom_range(1, 16));
      queue_random_words(200);
      settle_block();

      repeat (SETTLE_DELAY) @(posedge clock);
      if (failure_count == 0 && expected_updates.size() == 0)
         $display("PASS izhikevich_neuron_step_core");
      else
         $display("FAIL izhikevich_neuron_step_core");
      $finish;
   end

endmodule
